>>> rtl/core/cme_pkg.sv
// Shared types and constants for the conditional multiply-accumulate unit.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package cme_pkg;

    localparam int NUM_REGS = 16;
    localparam int REG_AW   = 4;

    // Instruction field positions
    localparam int COND_MSB = 31;
    localparam int COND_LSB = 28;
    localparam int ACC_BIT  = 21;
    localparam int SET_BIT  = 20;
    localparam int RD_MSB   = 19;
    localparam int RD_LSB   = 16;
    localparam int RN_MSB   = 15;
    localparam int RN_LSB   = 12;
    localparam int RS_MSB   = 11;
    localparam int RS_LSB   = 8;
    localparam int RM_MSB   = 3;
    localparam int RM_LSB   = 0;

    // Status word flag positions
    localparam int N_BIT  = 31;
    localparam int Z_BIT  = 30;
    localparam int V_BIT  = 28;
    localparam int KEEP_W = 30;

    localparam logic [4:0] STATUS_INDEX = 5'd16;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EXEC = 1'b1;

    typedef enum logic [3:0] {
        COND_EQ = 4'd0,
        COND_NE = 4'd1,
        COND_GE = 4'd10,
        COND_LT = 4'd11,
        COND_GT = 4'd12,
        COND_LE = 4'd13,
        COND_AL = 4'd14
    } cond_t;

    typedef struct packed {
        logic        action;
        logic [31:0] instruction;
        logic [4:0]  load_index;
        logic [31:0] load_value;
    } in_item_t;

    typedef struct packed {
        logic        executed;
        logic [3:0]  dest_index;
        logic [31:0] dest_value;
        logic [31:0] status_word;
    } out_item_t;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [31:0]       data;
    } reg_wr_t;

endpackage

>>> rtl/core/cme_regfile.sv
// Sixteen-entry register file: two identical banks give three read ports.
// Depends on cme_pkg for the write port struct and sizes.
module cme_regfile
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [cme_pkg::REG_AW-1:0] addr_m,
    input  logic [cme_pkg::REG_AW-1:0] addr_s,
    input  logic [cme_pkg::REG_AW-1:0] addr_n,
    input  cme_pkg::reg_wr_t           wr,
    output logic [31:0]                data_m,
    output logic [31:0]                data_s,
    output logic [31:0]                data_n
);

    logic [31:0] bank_a_mem [cme_pkg::NUM_REGS];
    logic [31:0] bank_b_mem [cme_pkg::NUM_REGS];
    logic [cme_pkg::NUM_REGS-1:0] valid_reg;

    logic [31:0] rdata_m_reg;
    logic [31:0] rdata_s_reg;
    logic [31:0] rdata_n_reg;
    logic        hit_m_reg;
    logic        hit_s_reg;
    logic        hit_n_reg;

    logic byp_m;
    logic byp_s;
    logic byp_n;

    // forward the retiring write into a read taken at the same edge
    assign byp_m = wr.en && (wr.addr == addr_m);
    assign byp_s = wr.en && (wr.addr == addr_s);
    assign byp_n = wr.en && (wr.addr == addr_n);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            bank_a_mem[wr.addr] <= wr.data;
            bank_b_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_m_reg <= byp_m ? wr.data : bank_a_mem[addr_m];
            rdata_s_reg <= byp_s ? wr.data : bank_a_mem[addr_s];
            rdata_n_reg <= byp_n ? wr.data : bank_b_mem[addr_n];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_m_reg <= 1'b0;
            hit_s_reg <= 1'b0;
            hit_n_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_m_reg <= byp_m || valid_reg[addr_m];
                hit_s_reg <= byp_s || valid_reg[addr_s];
                hit_n_reg <= byp_n || valid_reg[addr_n];
            end
        end
    end

    // an entry never written since reset reads as zero
    assign data_m = hit_m_reg ? rdata_m_reg : '0;
    assign data_s = hit_s_reg ? rdata_s_reg : '0;
    assign data_n = hit_n_reg ? rdata_n_reg : '0;

endmodule

>>> rtl/core/cme_alu.sv
// Condition check, multiply-accumulate, flag update and load decode for one beat.
// Depends on cme_pkg for the item structs, condition codes and bit positions.
module cme_alu
(
    input  cme_pkg::in_item_t  item,
    input  logic [31:0]        op_m,
    input  logic [31:0]        op_s,
    input  logic [31:0]        op_n,
    input  logic [31:0]        status,
    output cme_pkg::out_item_t result,
    output cme_pkg::reg_wr_t   wr,
    output logic [31:0]        status_next
);

    logic        flag_n;
    logic        flag_z;
    logic        flag_v;
    logic        cond_ok;
    logic [31:0] product;
    logic [31:0] sum;
    logic [3:0]  rd;

    assign flag_n = status[cme_pkg::N_BIT];
    assign flag_z = status[cme_pkg::Z_BIT];
    assign flag_v = status[cme_pkg::V_BIT];
    assign rd     = item.instruction[cme_pkg::RD_MSB:cme_pkg::RD_LSB];

    always_comb
    begin
        unique case (cme_pkg::cond_t'(item.instruction[cme_pkg::COND_MSB:cme_pkg::COND_LSB]))
            cme_pkg::COND_EQ: cond_ok = flag_z;
            cme_pkg::COND_NE: cond_ok = !flag_z;
            cme_pkg::COND_GE: cond_ok = (flag_n == flag_v);
            cme_pkg::COND_LT: cond_ok = (flag_n != flag_v);
            cme_pkg::COND_GT: cond_ok = !flag_z && (flag_n == flag_v);
            cme_pkg::COND_LE: cond_ok = flag_z || (flag_n != flag_v);
            cme_pkg::COND_AL: cond_ok = 1'b1;
            default:          cond_ok = 1'b0;
        endcase
    end

    assign product = 32'(op_m * op_s);
    assign sum     = product + (item.instruction[cme_pkg::ACC_BIT] ? op_n : 32'd0);

    always_comb
    begin
        wr          = '0;
        status_next = status;
        result      = '0;
        if (item.action == cme_pkg::ACT_LOAD)
        begin
            if (!item.load_index[4])
            begin
                wr.en   = 1'b1;
                wr.addr = item.load_index[3:0];
                wr.data = item.load_value;
            end
            else if (item.load_index == cme_pkg::STATUS_INDEX)
            begin
                status_next = item.load_value;
            end
        end
        else if (cond_ok)
        begin
            wr.en   = 1'b1;
            wr.addr = rd;
            wr.data = sum;
            if (item.instruction[cme_pkg::SET_BIT])
            begin
                status_next = {sum[31], (sum == 32'd0), status[cme_pkg::KEEP_W-1:0]};
            end
            result.executed   = 1'b1;
            result.dest_index = rd;
            result.dest_value = sum;
        end
        result.status_word = status_next;
    end

endmodule

>>> rtl/core/cond_multiply_accumulate_exec.sv
// Top level of the conditional multiply-accumulate unit.
// Depends on cme_pkg, cme_regfile and cme_alu.
//
// The unit holds sixteen 32-bit registers and a status word (N bit 31, Z bit 30,
// V bit 28). A load beat writes a register (index 0..15) or the status word
// (index 16); larger indexes are dropped. An execute beat tests the condition in
// bits 31..28 (eq, ne, ge, lt, gt, le, al; any other code fails) and on a pass
// writes Rm * Rs, low 32 bits, plus Rn when bit 21 is set, to Rd; bit 20 updates
// N and Z. Every beat gives exactly one result beat carrying the status word
// after it. One beat is taken every clock cycle as long as the result side keeps
// up; a taken beat is held in the operand stage and then loaded into the result
// register, which offers its result. The cycle in which a beat is taken reads
// the three source registers into registered read data (two banks of the
// register file, with the write retiring in that same cycle forwarded in); the
// operand stage then evaluates the condition against the status word, forms the
// product and sum, and on leaving writes back and loads the result register. The
// result register lets a new beat in while a finished result waits; when the
// result side stalls, the operand stage fills and then the input stalls too.
module cond_multiply_accumulate_exec
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  cme_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output cme_pkg::out_item_t result
);

    logic               s1_valid_reg;
    cme_pkg::in_item_t  s1_item_reg;
    logic               out_valid_reg;
    cme_pkg::out_item_t out_item_reg;
    logic [31:0]        status_reg;

    logic               accept;
    logic               advance;
    logic [31:0]        op_m;
    logic [31:0]        op_s;
    logic [31:0]        op_n;
    cme_pkg::out_item_t alu_result;
    cme_pkg::reg_wr_t   alu_wr;
    cme_pkg::reg_wr_t   rf_wr;
    logic [31:0]        status_next;

    // advance the operand stage whenever the result register is free or draining
    assign advance    = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    // write back only when the beat actually leaves the operand stage
    always_comb
    begin
        rf_wr    = alu_wr;
        rf_wr.en = alu_wr.en && advance;
    end

    cme_regfile u_regfile
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .addr_m (item.instruction[cme_pkg::RM_MSB:cme_pkg::RM_LSB]),
        .addr_s (item.instruction[cme_pkg::RS_MSB:cme_pkg::RS_LSB]),
        .addr_n (item.instruction[cme_pkg::RN_MSB:cme_pkg::RN_LSB]),
        .wr     (rf_wr),
        .data_m (op_m),
        .data_s (op_s),
        .data_n (op_n)
    );

    cme_alu u_alu
    (
        .item        (s1_item_reg),
        .op_m        (op_m),
        .op_s        (op_s),
        .op_n        (op_n),
        .status      (status_reg),
        .result      (alu_result),
        .wr          (alu_wr),
        .status_next (status_next)
    );

    // hold the beat's fields alongside the registered read data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= alu_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= status_next;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

`ifndef SYNTHESIS
    // input may only stall while the operand stage holds a beat it cannot pass on
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && out_valid_reg && result_stall))
        else $error("input stalled without a blocked operand stage");

    // a beat leaving the operand stage always lands in the result register
    a_advance_lands : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result_valid && (result.status_word == status_reg)))
        else $error("advanced beat lost or status mismatch");

    // a result that did not execute carries no destination
    a_idle_result : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.executed) |->
            (result.dest_index == 4'd0 && result.dest_value == 32'd0))
        else $error("non-executed result carries destination data");

    // an execute beat without the flag bit leaves the status word alone
    a_status_kept : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_item_reg.action == cme_pkg::ACT_EXEC
            && !s1_item_reg.instruction[cme_pkg::SET_BIT])
        |=> (status_reg == $past(status_reg)))
        else $error("status word changed without the flag bit");
`endif

endmodule

>>> test/cond_multiply_accumulate_exec_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for cond_multiply_accumulate_exec: load and execute beats
// against a cycle-free copy of the register file and status word. Needs cme_pkg.
module cond_multiply_accumulate_exec_tb;

    localparam int CLK_HALF       = 10;
    localparam int CLK_PERIOD     = 2 * CLK_HALF;
    localparam int RESET_CYCLES   = 6;
    localparam int MAX_IDLE       = 11;
    localparam int BLOCK_BEATS    = 50;
    localparam int RANDOM_BLOCKS  = 29;
    localparam int HOLD_OFF       = 64;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int REPORT_LIMIT   = 10;

    // Condition codes the unit does not support: they must never execute
    localparam logic [3:0] COND_UNUSED_LO = 4'd2;
    localparam logic [3:0] COND_UNUSED_HI = 4'd9;
    localparam logic [3:0] COND_RESERVED  = 4'd15;

    // Instruction bits 27..22 and 7..4 carry nothing
    localparam logic [31:0] UNUSED_BITS = 32'h0FC0_00F0;

    // Tracks the architectural state and queues the writeback each beat gives.
    class mla_tracker;
        logic [31:0]        regs [cme_pkg::NUM_REGS];
        logic [31:0]        status;
        cme_pkg::out_item_t expected_writebacks [$];
        int                 mismatches;
        int                 checked;
        int                 loads;
        int                 executes;
        int                 passed;

        function new();
            foreach (regs[i]) regs[i] = '0;
            status     = '0;
            mismatches = 0;
            checked    = 0;
            loads      = 0;
            executes   = 0;
            passed     = 0;
        endfunction

        function bit cond_holds(logic [3:0] cc);
            logic n;
            logic z;
            logic v;
            n = status[cme_pkg::N_BIT];
            z = status[cme_pkg::Z_BIT];
            v = status[cme_pkg::V_BIT];
            case (cc)
                cme_pkg::COND_EQ: return z;
                cme_pkg::COND_NE: return !z;
                cme_pkg::COND_GE: return n == v;
                cme_pkg::COND_LT: return n != v;
                cme_pkg::COND_GT: return !z && (n == v);
                cme_pkg::COND_LE: return z || (n != v);
                cme_pkg::COND_AL: return 1'b1;
                default:          return 1'b0;
            endcase
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void note_beat(cme_pkg::in_item_t it);
            cme_pkg::out_item_t want;
            logic [3:0]         rd;
            logic [31:0]        sum;
            want = '0;
            if (it.action == cme_pkg::ACT_LOAD)
            begin
                loads++;
                if (it.load_index < cme_pkg::STATUS_INDEX)
                    regs[it.load_index[cme_pkg::REG_AW-1:0]] = it.load_value;
                else if (it.load_index == cme_pkg::STATUS_INDEX)
                    status = it.load_value;
            end
            else
            begin
                executes++;
                if (cond_holds(it.instruction[cme_pkg::COND_MSB:cme_pkg::COND_LSB]))
                begin
                    // read every source before Rd is written, so overlap is harmless
                    rd  = it.instruction[cme_pkg::RD_MSB:cme_pkg::RD_LSB];
                    sum = regs[it.instruction[cme_pkg::RM_MSB:cme_pkg::RM_LSB]]
                        * regs[it.instruction[cme_pkg::RS_MSB:cme_pkg::RS_LSB]];
                    if (it.instruction[cme_pkg::ACC_BIT])
                        sum = sum + regs[it.instruction[cme_pkg::RN_MSB:cme_pkg::RN_LSB]];
                    regs[rd] = sum;
                    if (it.instruction[cme_pkg::SET_BIT])
                        status = {sum[cme_pkg::N_BIT], sum == 32'd0,
                                  status[cme_pkg::KEEP_W-1:0]};
                    want.executed   = 1'b1;
                    want.dest_index = rd;
                    want.dest_value = sum;
                    passed++;
                end
            end
            want.status_word = status;
            expected_writebacks.push_back(want);
        endfunction

        function void check_result(cme_pkg::out_item_t got);
            cme_pkg::out_item_t want;
            if (expected_writebacks.size() == 0)
            begin
                flag($sformatf("result with nothing outstanding: %h", got));
                return;
            end
            want = expected_writebacks.pop_front();
            checked++;
            if (got.executed !== want.executed || got.dest_index !== want.dest_index
                || got.dest_value !== want.dest_value
                || got.status_word !== want.status_word)
                flag($sformatf({"result %0d exp/act: executed %b/%b rd %0d/%0d ",
                                "value %h/%h status %h/%h"},
                               checked, want.executed, got.executed,
                               want.dest_index, got.dest_index,
                               want.dest_value, got.dest_value,
                               want.status_word, got.status_word));
        endfunction

        function int pending();
            return expected_writebacks.size();
        endfunction

        function void close_out();
            if (expected_writebacks.size() != 0)
                flag($sformatf("%0d results never arrived", expected_writebacks.size()));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    cme_pkg::in_item_t  item;
    logic               result_valid;
    logic               result_stall = 1'b0;
    cme_pkg::out_item_t result;

    mla_tracker book = new();

    // Idling switches and receiver counters, shared between the processes below
    bit tx_idle  = 1'b1;
    bit rx_idle  = 1'b1;
    int rx_wait  = 0;
    int hold_req = 0;
    int hold_left = 0;

    cond_multiply_accumulate_exec i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

    // Receiver: drive stall on the falling edge. A pending long hold-off wins
    // over the per-result wait; both count down one cycle at a time.
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Take result beats on the rising edge and draw the wait before the next one
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            book.check_result(result);
            rx_wait = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        end
    end

    function automatic cme_pkg::in_item_t load_beat(logic [4:0] idx, logic [31:0] value);
        cme_pkg::in_item_t it;
        it.action      = cme_pkg::ACT_LOAD;
        it.instruction = $urandom;
        it.load_index  = idx;
        it.load_value  = value;
        return it;
    endfunction

    // Unused instruction bits and the load fields are filled with noise
    function automatic cme_pkg::in_item_t exec_beat(logic [3:0] cc, bit acc, bit setf,
                                                    logic [3:0] rd, logic [3:0] rn,
                                                    logic [3:0] rs, logic [3:0] rm);
        cme_pkg::in_item_t it;
        it.action                                       = cme_pkg::ACT_EXEC;
        it.instruction                                  = $urandom;
        it.instruction[cme_pkg::COND_MSB:cme_pkg::COND_LSB] = cc;
        it.instruction[cme_pkg::ACC_BIT]                = acc;
        it.instruction[cme_pkg::SET_BIT]                = setf;
        it.instruction[cme_pkg::RD_MSB:cme_pkg::RD_LSB] = rd;
        it.instruction[cme_pkg::RN_MSB:cme_pkg::RN_LSB] = rn;
        it.instruction[cme_pkg::RS_MSB:cme_pkg::RS_LSB] = rs;
        it.instruction[cme_pkg::RM_MSB:cme_pkg::RM_LSB] = rm;
        it.load_index                                   = 5'($urandom_range(0, 31));
        it.load_value                                   = $urandom;
        return it;
    endfunction

    // Operand values leaning on the corners, so products wrap and hit zero
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'd1;
            4:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Offer one beat after an optional gap and hold it until it is taken
    task automatic send_beat(input cme_pkg::in_item_t it);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        book.note_beat(it);
    endtask

    initial
    begin
        cme_pkg::in_item_t it;
        logic [3:0]        cc;
        int                pick;
        int                guard;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: corner operands, ignored loads, every condition (eq, ne and gt both ways)
        send_beat(load_beat(5'd0, 32'hFFFF_FFFF));
        send_beat(load_beat(5'd1, 32'hFFFF_FFFF));
        send_beat(load_beat(5'd15, 32'h8000_0000));
        send_beat(load_beat(5'd2, 32'd3));
        send_beat(load_beat(5'd17, 32'h1234_5678));
        send_beat(load_beat(5'd31, 32'hFFFF_FFFF));
        // all-ones squared wraps to one; unused bits all set
        it = exec_beat(cme_pkg::COND_AL, 1'b0, 1'b1, 4'd3, 4'd0, 4'd1, 4'd0);
        it.instruction = it.instruction | UNUSED_BITS;
        send_beat(it);
        // product plus accumulator wraps to zero: Z set
        send_beat(exec_beat(cme_pkg::COND_AL, 1'b1, 1'b1, 4'd4, 4'd15, 4'd2, 4'd15));
        send_beat(exec_beat(cme_pkg::COND_EQ, 1'b0, 1'b1, 4'd0, 4'd0, 4'd0, 4'd0));
        send_beat(exec_beat(cme_pkg::COND_EQ, 1'b1, 1'b1, 4'd1, 4'd1, 4'd1, 4'd1));
        send_beat(exec_beat(cme_pkg::COND_NE, 1'b0, 1'b1, 4'd5, 4'd0, 4'd1, 4'd15));
        send_beat(exec_beat(cme_pkg::COND_GE, 1'b0, 1'b1, 4'd6, 4'd0, 4'd0, 4'd0));
        // Rd doubles as the accumulator
        send_beat(exec_beat(cme_pkg::COND_LT, 1'b1, 1'b0, 4'd6, 4'd6, 4'd2, 4'd2));
        send_beat(exec_beat(cme_pkg::COND_GT, 1'b0, 1'b1, 4'd7, 4'd0, 4'd0, 4'd0));
        send_beat(exec_beat(cme_pkg::COND_LE, 1'b0, 1'b0, 4'd7, 4'd0, 4'd6, 4'd6));
        send_beat(load_beat(cme_pkg::STATUS_INDEX, 32'h3FFF_FFFF));
        send_beat(exec_beat(cme_pkg::COND_GE, 1'b0, 1'b1, 4'd8, 4'd0, 4'd0, 4'd0));
        // zero result with low status bits set: keep them
        send_beat(exec_beat(cme_pkg::COND_LT, 1'b0, 1'b1, 4'd8, 4'd0, 4'd0, 4'd4));
        send_beat(exec_beat(cme_pkg::COND_LE, 1'b0, 1'b0, 4'd10, 4'd0, 4'd7, 4'd7));
        send_beat(exec_beat(cme_pkg::COND_NE, 1'b0, 1'b1, 4'd11, 4'd0, 4'd1, 4'd1));
        send_beat(load_beat(cme_pkg::STATUS_INDEX, 32'h9000_0000));
        send_beat(exec_beat(cme_pkg::COND_GT, 1'b1, 1'b1, 4'd9, 4'd1, 4'd0, 4'd0));
        send_beat(exec_beat(COND_RESERVED, 1'b1, 1'b1, 4'd12, 4'd1, 4'd1, 4'd1));
        send_beat(exec_beat(COND_UNUSED_LO, 1'b0, 1'b1, 4'd13, 4'd1, 4'd1, 4'd1));
        send_beat(exec_beat(COND_UNUSED_HI, 1'b1, 1'b0, 4'd14, 4'd1, 4'd1, 4'd1));

        // Random: blocks cycle through every mix of sender and receiver idling
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            tx_idle = blk[0];
            rx_idle = blk[1];
            for (int n = 0; n < BLOCK_BEATS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    it = load_beat(5'($urandom_range(0, cme_pkg::NUM_REGS - 1)),
                                   pick_word());
                else if (pick < 38)
                    it = load_beat(cme_pkg::STATUS_INDEX, $urandom);
                else if (pick < 42)
                    it = load_beat(5'($urandom_range(cme_pkg::STATUS_INDEX + 1, 31)),
                                   $urandom);
                else
                begin
                    if ($urandom_range(0, 3) != 0)
                        case ($urandom_range(0, 6))
                            0:       cc = cme_pkg::COND_EQ;
                            1:       cc = cme_pkg::COND_NE;
                            2:       cc = cme_pkg::COND_GE;
                            3:       cc = cme_pkg::COND_LT;
                            4:       cc = cme_pkg::COND_GT;
                            5:       cc = cme_pkg::COND_LE;
                            default: cc = cme_pkg::COND_AL;
                        endcase
                    else
                        cc = 4'($urandom_range(0, 15));
                    it = exec_beat(cc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
                end
                send_beat(it);
                // back-pressure: hold the result side off while beats keep coming
                if ((blk == 4 || blk == 12) && n == 0)
                    hold_req = HOLD_OFF;
            end
        end

        @(negedge clk);
        item_valid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        guard = 0;
        while (book.pending() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        book.close_out();

        $display("Run covered %0d loads and %0d executes (%0d took their condition).",
                 book.loads, book.executes, book.passed);
        $display("%0d results compared, %0d mismatches.", book.checked, book.mismatches);
        if (book.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
